### hdl/pos_pkg.sv
`default_nettype none

package pos_pkg;

  // Encoder geometry: counts per turn is a power of two.
  localparam int CPT_LOG2        = 12;
  localparam int COUNTS_PER_TURN = 1 << CPT_LOG2;

  // Fixed-point constants, Q8.24.
  localparam int TWO_PI_W = 27;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q24 = 27'd105403170;
  localparam logic signed [31:0] PI_Q24   = 32'sd52701585;
  localparam logic signed [31:0] VLIM_Q24 = 32'sd83886080;
  localparam logic signed [31:0] ONE_Q24  = 32'sd16777216;
  localparam int ALPHA_PW = TWO_PI_W + CPT_LOG2;

  // Register widths.
  localparam int ANGLE_W = 26;
  localparam int TICK_W  = 24;
  localparam int CFG_W   = 26;
  localparam int DAC_W   = 28;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CAPTURE_LIMIT = 2'd0,
    REG_REF_AMPLITUDE = 2'd1,
    REG_REF_PERIOD    = 2'd2,
    REG_REF_HIGH      = 2'd3
  } cfg_idx_t;

  // Multiply-accumulate program.
  localparam int TERM_W = 6;
  localparam logic [TERM_W-1:0] LAST_TERM = 6'd37;

  typedef enum logic [3:0] {
    SRC_POT, SRC_THETA, SRC_ALPHA,
    SRC_STATE0, SRC_STATE1, SRC_STATE2, SRC_STATE3,
    SRC_XHAT0, SRC_XHAT1, SRC_XHAT2, SRC_XHAT3,
    SRC_AREF, SRC_USAT
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_THETA,
    DST_XHAT0, DST_XHAT1, DST_XHAT2, DST_XHAT3,
    DST_U,
    DST_PRED0, DST_PRED1, DST_PRED2, DST_PRED3
  } dst_t;

  typedef struct packed {
    src_t               src;
    logic signed [31:0] coef;
    logic               first;
    logic               last;
    dst_t               dst;
  } term_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_ALPHA, ST_CHECK, ST_MUL, ST_ACC, ST_FINISH
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic              load_in;
    logic              calc_alpha;
    logic              check;
    logic              mul_en;
    logic              acc_en;
    logic              finish;
    logic [TERM_W-1:0] term;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_of_range;
    logic out_free;
    logic div_done;
  } dp_stat_t;

  function automatic term_t mk(src_t s, logic signed [31:0] c, logic f, logic l, dst_t d);
    term_t t;
    t.src = s;
    t.coef = c;
    t.first = f;
    t.last = l;
    t.dst = d;
    return t;
  endfunction

  // Term program: estimate correction, feedback, then next prediction.
  function automatic term_t term_info(logic [TERM_W-1:0] idx);
    term_t t;
    case (idx)
      6'd0:  t = mk(SRC_POT,    -32'sd10306088, 1'b1, 1'b1, DST_THETA);
      6'd1:  t = mk(SRC_STATE0, ONE_Q24,        1'b1, 1'b0, DST_NONE);
      6'd2:  t = mk(SRC_THETA,  32'sd9185526,   1'b0, 1'b0, DST_NONE);
      6'd3:  t = mk(SRC_ALPHA,  32'sd0,         1'b0, 1'b1, DST_XHAT0);
      6'd4:  t = mk(SRC_STATE1, ONE_Q24,        1'b1, 1'b0, DST_NONE);
      6'd5:  t = mk(SRC_THETA,  32'sd0,         1'b0, 1'b0, DST_NONE);
      6'd6:  t = mk(SRC_ALPHA,  32'sd15441750,  1'b0, 1'b1, DST_XHAT1);
      6'd7:  t = mk(SRC_STATE2, ONE_Q24,        1'b1, 1'b0, DST_NONE);
      6'd8:  t = mk(SRC_THETA,  32'sd98986,     1'b0, 1'b0, DST_NONE);
      6'd9:  t = mk(SRC_ALPHA,  -32'sd325478,   1'b0, 1'b1, DST_XHAT2);
      6'd10: t = mk(SRC_STATE3, ONE_Q24,        1'b1, 1'b0, DST_NONE);
      6'd11: t = mk(SRC_THETA,  -32'sd265080,   1'b0, 1'b0, DST_NONE);
      6'd12: t = mk(SRC_ALPHA,  32'sd15000509,  1'b0, 1'b1, DST_XHAT3);
      6'd13: t = mk(SRC_XHAT0,  -32'sd87025097, 1'b1, 1'b0, DST_NONE);
      6'd14: t = mk(SRC_XHAT1,  32'sd467148158, 1'b0, 1'b0, DST_NONE);
      6'd15: t = mk(SRC_XHAT2,  -32'sd45793411, 1'b0, 1'b0, DST_NONE);
      6'd16: t = mk(SRC_XHAT3,  32'sd53463954,  1'b0, 1'b0, DST_NONE);
      6'd17: t = mk(SRC_AREF,   32'sd87025097,  1'b0, 1'b1, DST_U);
      6'd18: t = mk(SRC_USAT,   32'sd0,         1'b1, 1'b0, DST_NONE);
      6'd19: t = mk(SRC_XHAT0,  32'sd7591690,   1'b0, 1'b0, DST_NONE);
      6'd20: t = mk(SRC_XHAT1,  32'sd0,         1'b0, 1'b0, DST_NONE);
      6'd21: t = mk(SRC_XHAT2,  32'sd6711,      1'b0, 1'b0, DST_NONE);
      6'd22: t = mk(SRC_XHAT3,  32'sd0,         1'b0, 1'b1, DST_PRED0);
      6'd23: t = mk(SRC_USAT,   32'sd0,         1'b1, 1'b0, DST_NONE);
      6'd24: t = mk(SRC_XHAT0,  32'sd0,         1'b0, 1'b0, DST_NONE);
      6'd25: t = mk(SRC_XHAT1,  32'sd1335466,   1'b0, 1'b0, DST_NONE);
      6'd26: t = mk(SRC_XHAT2,  32'sd0,         1'b0, 1'b0, DST_NONE);
      6'd27: t = mk(SRC_XHAT3,  32'sd1678,      1'b0, 1'b1, DST_PRED1);
      6'd28: t = mk(SRC_USAT,   32'sd1367343,   1'b1, 1'b0, DST_NONE);
      6'd29: t = mk(SRC_XHAT0,  -32'sd98986,    1'b0, 1'b0, DST_NONE);
      6'd30: t = mk(SRC_XHAT1,  32'sd1660944,   1'b0, 1'b0, DST_NONE);
      6'd31: t = mk(SRC_XHAT2,  32'sd16025597,  1'b0, 1'b0, DST_NONE);
      6'd32: t = mk(SRC_XHAT3,  -32'sd15099,    1'b0, 1'b1, DST_PRED2);
      6'd33: t = mk(SRC_USAT,   32'sd1315334,   1'b1, 1'b0, DST_NONE);
      6'd34: t = mk(SRC_XHAT0,  32'sd265080,    1'b0, 1'b0, DST_NONE);
      6'd35: t = mk(SRC_XHAT1,  -32'sd12985565, 1'b0, 1'b0, DST_NONE);
      6'd36: t = mk(SRC_XHAT2,  -32'sd723098,   1'b0, 1'b0, DST_NONE);
      6'd37: t = mk(SRC_XHAT3,  32'sd16740306,  1'b0, 1'b1, DST_PRED3);
      default: t = mk(SRC_POT,  32'sd0,         1'b1, 1'b1, DST_NONE);
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/pos_in_if.sv
`default_nettype none

interface pos_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pot_volts;
  logic signed [31:0] pendulum_count;

  modport source (output valid, pot_volts, pendulum_count, input ready);
  modport sink (input valid, pot_volts, pendulum_count, output ready);
endinterface

`default_nettype wire

### hdl/pos_out_if.sv
`default_nettype none

interface pos_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pos_pkg::DAC_W-1:0]    dac_drive;
  logic signed [31:0]                  control_unsaturated;
  logic                                in_range;

  modport source (output valid, dac_drive, control_unsaturated, in_range, input ready);
  modport sink (input valid, dac_drive, control_unsaturated, in_range, output ready);
endinterface

`default_nettype wire

### hdl/pos_ctrl.sv
`default_nettype none

module pos_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pos_pkg::dp_stat_t stat,
  output pos_pkg::dp_cmd_t      cmd
);

  pos_pkg::ctl_state_t              state_r, state_nxt;
  logic [pos_pkg::TERM_W-1:0]       term_r, term_nxt;

  // State and term counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pos_pkg::ST_IDLE;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      pos_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pos_pkg::ST_ALPHA;
      end
      pos_pkg::ST_ALPHA: state_nxt = pos_pkg::ST_CHECK;
      pos_pkg::ST_CHECK: begin
        term_nxt = '0;
        if (stat.out_of_range) state_nxt = pos_pkg::ST_FINISH;
        else state_nxt = pos_pkg::ST_MUL;
      end
      pos_pkg::ST_MUL: state_nxt = pos_pkg::ST_ACC;
      pos_pkg::ST_ACC: begin
        if (term_r == pos_pkg::LAST_TERM) begin
          state_nxt = pos_pkg::ST_FINISH;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = pos_pkg::ST_MUL;
        end
      end
      pos_pkg::ST_FINISH: begin
        if (stat.out_free && stat.div_done) state_nxt = pos_pkg::ST_IDLE;
      end
      default: state_nxt = pos_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.term       = term_r;
    case (state_r)
      pos_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      pos_pkg::ST_ALPHA:  cmd.calc_alpha = 1'b1;
      pos_pkg::ST_CHECK:  cmd.check = 1'b1;
      pos_pkg::ST_MUL:    cmd.mul_en = 1'b1;
      pos_pkg::ST_ACC:    cmd.acc_en = 1'b1;
      pos_pkg::ST_FINISH: cmd.finish = stat.out_free && stat.div_done;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == pos_pkg::ST_ALPHA))
    else $error("accepted request did not start processing");
  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (term_r <= pos_pkg::LAST_TERM))
    else $error("term counter ran past the program");
`endif

endmodule

`default_nettype wire

### hdl/pos_dp.sv
`default_nettype none

module pos_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pos_pkg::dp_cmd_t              cmd,
  output pos_pkg::dp_stat_t                  stat,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [pos_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic signed [31:0]            in_pot,
  input  wire logic signed [31:0]            in_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [pos_pkg::DAC_W-1:0]   out_dac,
  output logic signed [31:0]                 out_ctrl,
  output logic                               out_rng
);

  // Configuration registers.
  logic [pos_pkg::ANGLE_W-1:0] cap_limit_r, ref_amp_r;
  logic [pos_pkg::TICK_W-1:0]  ref_period_r, ref_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_limit_r  <= 26'd8783598;
      ref_amp_r    <= 26'd5855732;
      ref_period_r <= 24'd20000;
      ref_high_r   <= 24'd10000;
    end else if (cfg_we) begin
      case (pos_pkg::cfg_idx_t'(cfg_addr))
        pos_pkg::REG_CAPTURE_LIMIT: cap_limit_r  <= cfg_wdata;
        pos_pkg::REG_REF_AMPLITUDE: ref_amp_r    <= cfg_wdata;
        pos_pkg::REG_REF_PERIOD:    ref_period_r <= cfg_wdata[pos_pkg::TICK_W-1:0];
        pos_pkg::REG_REF_HIGH:      ref_high_r   <= cfg_wdata[pos_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture and tick counter.
  logic signed [31:0]            pot_r;
  logic [pos_pkg::CPT_LOG2-1:0]  cnt_r;
  logic [31:0]                   tick_r;
  logic [31:0]                   tick_nxt;

  assign tick_nxt = tick_r + 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pot_r <= in_pot;
      cnt_r <= in_count[pos_pkg::CPT_LOG2-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tick_r <= '0;
    else if (cmd.load_in) tick_r <= tick_nxt;
  end

  // Restoring divider for the reference phase, one quotient bit a cycle.
  logic [31:0]                dvd_r;
  logic [pos_pkg::TICK_W-1:0] rem_r;
  logic [5:0]                 div_cnt_r;
  logic [pos_pkg::TICK_W:0]   div_trial;

  assign div_trial = {rem_r, dvd_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.load_in) begin
      div_cnt_r <= 6'd32;
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dvd_r <= tick_nxt;
      rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (div_trial >= {1'b0, ref_period_r})
        rem_r <= pos_pkg::TICK_W'(div_trial - {1'b0, ref_period_r});
      else
        rem_r <= div_trial[pos_pkg::TICK_W-1:0];
    end
  end

  // Pendulum angle: scale the count within one turn and shift upright to zero.
  logic [pos_pkg::ALPHA_PW-1:0] alpha_prod;
  logic signed [31:0]           alpha_r;
  logic signed [31:0]           alpha_mag;

  assign alpha_prod = pos_pkg::ALPHA_PW'(cnt_r) * pos_pkg::ALPHA_PW'(pos_pkg::TWO_PI_Q24)
                    + pos_pkg::ALPHA_PW'(pos_pkg::COUNTS_PER_TURN / 2);
  assign alpha_mag  = alpha_r[31] ? -alpha_r : alpha_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_alpha)
      alpha_r <= $signed({5'd0, alpha_prod[pos_pkg::ALPHA_PW-1:pos_pkg::CPT_LOG2]})
               - pos_pkg::PI_Q24;
  end

  assign stat.out_of_range = alpha_mag > $signed({6'd0, cap_limit_r});

  // Working registers of the estimator.
  logic signed [31:0] state_r [4];
  logic signed [31:0] xhat_r [4];
  logic signed [31:0] theta_r, u_r, usat_r, aref_r;
  logic               active_r;

  // Operand selection and the shared multiplier.
  pos_pkg::term_t     term;
  logic signed [31:0] opa;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] rnd_sum;
  logic signed [39:0] rnd_q;
  logic signed [31:0] res;
  logic signed [31:0] res_sat;

  assign term = pos_pkg::term_info(cmd.term);

  always_comb begin
    case (term.src)
      pos_pkg::SRC_POT:    opa = pot_r;
      pos_pkg::SRC_THETA:  opa = theta_r;
      pos_pkg::SRC_ALPHA:  opa = alpha_r;
      pos_pkg::SRC_STATE0: opa = state_r[0];
      pos_pkg::SRC_STATE1: opa = state_r[1];
      pos_pkg::SRC_STATE2: opa = state_r[2];
      pos_pkg::SRC_STATE3: opa = state_r[3];
      pos_pkg::SRC_XHAT0:  opa = xhat_r[0];
      pos_pkg::SRC_XHAT1:  opa = xhat_r[1];
      pos_pkg::SRC_XHAT2:  opa = xhat_r[2];
      pos_pkg::SRC_XHAT3:  opa = xhat_r[3];
      pos_pkg::SRC_AREF:   opa = aref_r;
      pos_pkg::SRC_USAT:   opa = usat_r;
      default:             opa = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= 64'(opa) * 64'(term.coef);
  end

  // Accumulate, then round once at Q8.24 and saturate to 32 bits.
  assign acc_nxt = (term.first ? 64'sd0 : acc_r) + prod_r;
  assign rnd_sum = acc_nxt + 64'sd8388608;
  assign rnd_q   = rnd_sum[63:24];

  always_comb begin
    if (rnd_q > 40'sh007FFFFFFF)       res = 32'sh7FFFFFFF;
    else if (rnd_q < -40'sh0080000000) res = 32'sh80000000;
    else                               res = rnd_q[31:0];
  end

  always_comb begin
    if (res > pos_pkg::VLIM_Q24)       res_sat = pos_pkg::VLIM_Q24;
    else if (res < -pos_pkg::VLIM_Q24) res_sat = -pos_pkg::VLIM_Q24;
    else                               res_sat = res;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) acc_r <= acc_nxt;
  end

  // Result write-back to the term's destination.
  always_ff @(posedge clk) begin
    if (cmd.acc_en && term.last) begin
      case (term.dst)
        pos_pkg::DST_THETA: theta_r <= res;
        pos_pkg::DST_XHAT0: xhat_r[0] <= res;
        pos_pkg::DST_XHAT1: xhat_r[1] <= res;
        pos_pkg::DST_XHAT2: xhat_r[2] <= res;
        pos_pkg::DST_XHAT3: xhat_r[3] <= res;
        pos_pkg::DST_U: begin
          u_r    <= res;
          usat_r <= res_sat;
        end
        default: ;
      endcase
    end
  end

  // Predicted state: cleared by reset and while the pendulum is outside capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) state_r[i] <= '0;
    end else if (cmd.check && stat.out_of_range) begin
      for (int i = 0; i < 4; i++) state_r[i] <= '0;
    end else if (cmd.acc_en && term.last) begin
      case (term.dst)
        pos_pkg::DST_PRED0: state_r[0] <= res;
        pos_pkg::DST_PRED1: state_r[1] <= res;
        pos_pkg::DST_PRED2: state_r[2] <= res;
        pos_pkg::DST_PRED3: state_r[3] <= res;
        default: ;
      endcase
    end
  end

  // Active flag and the square-wave arm reference.
  logic [31:0] phase;

  assign phase = (ref_period_r == '0) ? tick_r : {8'd0, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      aref_r   <= '0;
    end else begin
      if (cmd.check) active_r <= !stat.out_of_range;
      if (cmd.finish && active_r) begin
        if (phase < {8'd0, ref_high_r}) aref_r <= $signed({6'd0, ref_amp_r});
        else aref_r <= -$signed({6'd0, ref_amp_r});
      end
    end
  end

  assign stat.div_done = (div_cnt_r == '0);

  // Output register.
  logic                              out_valid_r;
  logic signed [pos_pkg::DAC_W-1:0]  out_dac_r;
  logic signed [31:0]                out_ctrl_r;
  logic                              out_rng_r;

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dac_r  <= active_r ? pos_pkg::DAC_W'(-usat_r) : '0;
      out_ctrl_r <= active_r ? u_r : '0;
      out_rng_r  <= active_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dac   = out_dac_r;
  assign out_ctrl  = out_ctrl_r;
  assign out_rng   = out_rng_r;

`ifndef SYNTHESIS
  a_dac_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dac_r <= 28'sd83886080 && out_dac_r >= -28'sd83886080))
    else $error("drive beyond the voltage limit");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rng_r) |-> (out_dac_r == '0 && out_ctrl_r == '0))
    else $error("nonzero drive while out of capture range");
  a_dac_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rng_r && out_ctrl_r <= pos_pkg::VLIM_Q24
     && out_ctrl_r >= -pos_pkg::VLIM_Q24) |-> (32'(out_dac_r) == -out_ctrl_r))
    else $error("drive does not match the unclamped control");
`endif

endmodule

`default_nettype wire

### hdl/pendulum_observer_state_feedback.sv
`default_nettype none

// Pendulum observer with state feedback, one request per 1 ms control tick.
// Each request (arm potentiometer volts, raw pendulum count) yields one
// response with the negated, +-5 V clamped drive, the unclamped control and
// an in-range flag; volts and control are signed Q8.24, the drive Q4.24.
// Inside the capture angle a request runs 38 multiply-accumulate terms,
// each a multiply and an accumulate step on a single shared 32x32
// multiplier, plus capture, angle and check steps; outside it the terms are
// skipped and the reference-phase divider sets the length. A further request
// is taken only after the previous one completes; a finished response waits
// in an output register. The user must write configuration through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
module pendulum_observer_state_feedback (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  pos_in_if.sink                         in_ch,
  pos_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_addr,
  input  wire logic [pos_pkg::CFG_W-1:0] cfg_wdata
);

  pos_pkg::dp_cmd_t  cmd;
  pos_pkg::dp_stat_t stat;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  pos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  pos_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_pot    (in_ch.pot_volts),
    .in_count  (in_ch.pendulum_count),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dac   (out_ch.dac_drive),
    .out_ctrl  (out_ch.control_unsaturated),
    .out_rng   (out_ch.in_range)
  );

endmodule

`default_nettype wire
